### rtl/sii_pkg.sv
// sii_pkg: shared codes and control types for the set intersection block
// used by sii_ctrl, sii_dp and the top level; no dependencies
package sii_pkg;

  localparam int INDEX_W  = 6;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 32;

  // item selector codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND_FIRST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_SECOND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN           = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic append;     // accepted append item
    logic run_empty;  // run with an empty list: error result and clear
    logic run_start;  // run begins at first-list entry zero
    logic rd_cur;     // read current first-list entry
    logic latch;      // capture current value, reset scan flags
    logic scan;       // issue reads at scan pointer and advance it
    logic decide;     // report held match if a new one is found, move on
    logic flush;      // closing cycle: final result, clear lists
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic any_empty;  // one of the lists holds nothing
    logic scan_last;  // scan pointer is at its final address
    logic entry_last; // current entry is the last of the first list
  } stat_t;

endpackage

### rtl/sii_ctrl.sv
// sii_ctrl: run sequencer for the set intersection block
// depends on sii_pkg for the command and status structs
module sii_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sii_pkg::FUNC_W-1:0]  in_func,
  input  sii_pkg::stat_t              stat,
  output sii_pkg::cmd_t               cmd,
  output logic                        busy
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RD_CUR = 7'b0000010,
    S_LATCH  = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == sii_pkg::FUNC_APPEND_FIRST ||
              in_func == sii_pkg::FUNC_APPEND_SECOND) begin
            cmd.append = 1'b1;
          end else if (in_func == sii_pkg::FUNC_RUN) begin
            if (stat.any_empty) begin
              cmd.run_empty = 1'b1;
            end else begin
              cmd.run_start = 1'b1;
              state_nxt     = S_RD_CUR;
            end
          end
        end
      end
      S_RD_CUR: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.entry_last ? S_FLUSH : S_RD_CUR;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/sii_dp.sv
// sii_dp: list memories, counters, compare pipeline and result registers
// depends on sii_pkg; driven by commands from sii_ctrl
module sii_dp #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sii_pkg::cmd_t                 cmd,
  input  logic [sii_pkg::FUNC_W-1:0]    in_func,
  input  logic signed [sii_pkg::IN_W-1:0] in_value,
  output sii_pkg::stat_t                stat,
  output logic                          out_valid,
  output logic [sii_pkg::INDEX_W-1:0]   out_index,
  output logic                          out_found,
  output logic [sii_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [VALUE_WIDTH-1:0] first_mem  [DEPTH];
  logic [VALUE_WIDTH-1:0] second_mem [DEPTH];

  logic [CW-1:0]          first_cnt_r, second_cnt_r;
  logic                   ovf_r;
  logic [IW-1:0]          i_r, j_r, jd_r;
  logic                   pvld_r, dup_r, common_r, pend_vld_r;
  logic [sii_pkg::INDEX_W-1:0] pend_idx_r;
  logic [VALUE_WIDTH-1:0] cur_r, rd_a_r, rd_b_r;
  logic [IW-1:0]          rd_addr_a;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic [CW-1:0]          scan_end;
  logic                   first_full, second_full, is_match;
  logic [sii_pkg::STATUS_W-1:0] run_status;

  logic                          out_valid_r, out_found_r, out_last_r;
  logic [sii_pkg::INDEX_W-1:0]   out_index_r;
  logic [sii_pkg::STATUS_W-1:0]  out_status_r;

  // sign extend or truncate the incoming value to storage width
  assign wr_val      = VALUE_WIDTH'(in_value);
  assign first_full  = (first_cnt_r == CW'(DEPTH));
  assign second_full = (second_cnt_r == CW'(DEPTH));
  assign rd_addr_a   = cmd.rd_cur ? i_r : j_r;
  assign scan_end    = (CW'(i_r) > second_cnt_r) ? CW'(i_r) : second_cnt_r;
  assign is_match    = common_r && !dup_r;
  assign run_status  = ovf_r ? sii_pkg::ST_OVERFLOW : sii_pkg::ST_OK;

  assign stat.any_empty  = (first_cnt_r == '0) || (second_cnt_r == '0);
  assign stat.scan_last  = ((CW'(j_r) + CW'(1)) == scan_end);
  assign stat.entry_last = ((CW'(i_r) + CW'(1)) == first_cnt_r);

  // list memories
  always_ff @(posedge clk) begin
    if (cmd.append && in_func == sii_pkg::FUNC_APPEND_FIRST && !first_full) begin
      first_mem[first_cnt_r[IW-1:0]] <= wr_val;
    end
    if (cmd.append && in_func == sii_pkg::FUNC_APPEND_SECOND && !second_full) begin
      second_mem[second_cnt_r[IW-1:0]] <= wr_val;
    end
    rd_a_r <= first_mem[rd_addr_a];
    rd_b_r <= second_mem[j_r];
  end

  // fill counts and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
    end else if (cmd.run_empty || cmd.flush) begin
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
    end else if (cmd.append) begin
      if (in_func == sii_pkg::FUNC_APPEND_FIRST) begin
        if (first_full) ovf_r <= 1'b1;
        else first_cnt_r <= first_cnt_r + CW'(1);
      end else begin
        if (second_full) ovf_r <= 1'b1;
        else second_cnt_r <= second_cnt_r + CW'(1);
      end
    end
  end

  // entry and scan pointers, compare pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= cmd.scan;
    end
    jd_r <= j_r;
    if (cmd.run_start) begin
      i_r        <= '0;
      pend_vld_r <= 1'b0;
    end
    if (cmd.latch) begin
      cur_r    <= rd_a_r;
      j_r      <= '0;
      dup_r    <= 1'b0;
      common_r <= 1'b0;
    end
    if (cmd.scan) begin
      j_r <= j_r + IW'(1);
    end
    if (pvld_r) begin
      if (jd_r < i_r && rd_a_r == cur_r) dup_r <= 1'b1;
      if (CW'(jd_r) < second_cnt_r && rd_b_r == cur_r) common_r <= 1'b1;
    end
    if (cmd.decide) begin
      i_r <= i_r + IW'(1);
      // hold the newest match until it is known whether another follows
      if (is_match) begin
        pend_vld_r <= 1'b1;
        pend_idx_r <= sii_pkg::INDEX_W'(i_r);
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.run_empty || cmd.flush ||
                     (cmd.decide && is_match && pend_vld_r);
    end
    if (cmd.run_empty) begin
      out_index_r  <= '0;
      out_found_r  <= 1'b0;
      out_status_r <= sii_pkg::ST_EMPTY;
      out_last_r   <= 1'b1;
    end else if (cmd.flush) begin
      out_index_r  <= pend_vld_r ? pend_idx_r : '0;
      out_found_r  <= pend_vld_r;
      out_status_r <= run_status;
      out_last_r   <= 1'b1;
    end else if (cmd.decide) begin
      out_index_r  <= pend_idx_r;
      out_found_r  <= 1'b1;
      out_status_r <= run_status;
      out_last_r   <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

### rtl/set_intersection_indices.sv
// set_intersection_indices: append is taken without leaving idle, start may be high again next cycle
// run with an empty list: one result in the cycle after the run item
// run: each entry i: read, latch, scan max(i, second count) addresses, drain, decide; then flush
// a match leaves when the next one is found, the final one after the closing flush with out_last
// results are one-cycle out_valid strobes; the receiver cannot stall
// synchronous active-low reset empties both lists; no clearing pass, reads past fill counts masked
module set_intersection_indices #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [sii_pkg::FUNC_W-1:0]      in_func,
  input  logic signed [sii_pkg::IN_W-1:0] in_value,
  output logic                            out_valid,
  output logic [sii_pkg::INDEX_W-1:0]     out_index,
  output logic                            out_found,
  output logic [sii_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_last
);

  // command and status between sequencer and datapath
  sii_pkg::cmd_t  cmd;
  sii_pkg::stat_t stat;

  // sequencer: walks each first-list entry, scans both lists, then reports
  sii_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // datapath: one memory per list, duplicate and membership compare, result regs
  sii_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_func    (in_func),
    .in_value   (in_value),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_index  (out_index),
    .out_found  (out_found),
    .out_status (out_status),
    .out_last   (out_last)
  );

  // a run always ends with its final item as the sequencer goes idle
  a_end_of_run: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid && out_last)
    else $error("run ended without a final item");

  // the final item only appears once the block is idle again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final item while still busy");

  // intermediate items only while a run is in progress
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy && out_found)
    else $error("intermediate item outside a run");

  // a match never carries the empty-list status
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status != sii_pkg::ST_EMPTY)
    else $error("match reported with empty status");

endmodule
